### sv/aus_pkg.sv
// Package: shared types and constants of the access unit splitter.
package aus_pkg;

    localparam int unsigned STEP_W = 20;
    localparam int unsigned OUT_TIME_W = 48;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STEP_W-1:0] TIME_STEP_RESET = 20'd33333;
    localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
    localparam logic [7:0] FIRST_SLICE_BIT = 8'h80;
    localparam logic [4:0] NAL_SLICE_NON_IDR = 5'd1;
    localparam logic [4:0] NAL_SLICE_IDR = 5'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_item;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  unit_start;
        logic [OUT_TIME_W-1:0] unit_time;
    } t_out_item;

    // Classified beat handed from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       unit_start;
        logic       time_step;
    } t_work;

endpackage

### sv/aus_front.sv
// Front: lookahead window, start code detection and access unit classification.
module aus_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  aus_pkg::t_in_item i_in_item,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output aus_pkg::t_work   o_push_data
);
    import aus_pkg::*;

    logic [7:0] r_window [4];
    logic [2:0] r_fill;
    logic       r_synced;
    logic       r_slice_seen;

    logic       accept;
    logic       full;
    logic       sc;
    logic       is_slice;
    logic [4:0] hdr_type;
    logic       step;

    assign o_in_ready = i_push_ready;
    assign accept = i_in_valid && o_in_ready;
    assign full = (r_fill == 3'd4);

    assign hdr_type = 5'(r_window[3] & NAL_TYPE_MASK);
    assign sc = (r_window[0] == 8'h00) && (r_window[1] == 8'h00) && (r_window[2] == 8'h01);
    assign is_slice = sc && ((hdr_type == NAL_SLICE_NON_IDR) || (hdr_type == NAL_SLICE_IDR));
    // A first slice after an earlier slice opens a new unit and moves the clock on.
    assign step = r_synced && is_slice && r_slice_seen
                  && ((i_in_item.data_byte & FIRST_SLICE_BIT) != 8'h00);

    assign o_push_valid = i_in_valid && !i_in_item.restart && full && (r_synced || sc);
    assign o_push_data.data_byte = r_window[0];
    assign o_push_data.unit_start = r_synced ? step : sc;
    assign o_push_data.time_step = step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 3'd0;
            r_synced <= 1'b0;
            r_slice_seen <= 1'b0;
        end else if (accept) begin
            if (i_in_item.restart) begin
                r_fill <= 3'd0;
                r_synced <= 1'b0;
                r_slice_seen <= 1'b0;
            end else if (!full) begin
                r_fill <= r_fill + 3'd1;
            end else begin
                r_synced <= r_synced || sc;
                r_slice_seen <= r_slice_seen || is_slice;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_in_item.restart) begin
            if (!full) begin
                r_window[r_fill[1:0]] <= i_in_item.data_byte;
            end else begin
                r_window[0] <= r_window[1];
                r_window[1] <= r_window[2];
                r_window[2] <= r_window[3];
                r_window[3] <= i_in_item.data_byte;
            end
        end
    end

endmodule

### sv/aus_queue.sv
// Queue: short first-in first-out buffer between the front and the back.
module aus_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  aus_pkg::t_work i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output aus_pkg::t_work o_pop_data
);
    import aus_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data = r_mem[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### sv/aus_back.sv
// Back: timestamp counter, step register and output register.
module aus_back #(
    parameter int unsigned TIME_BITS = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_time_step_we,
    input  logic [aus_pkg::STEP_W-1:0] i_time_step,
    input  logic                       i_pop_valid,
    output logic                       o_pop_ready,
    input  aus_pkg::t_work             i_pop_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output aus_pkg::t_out_item         o_out_item
);
    import aus_pkg::*;

    logic [STEP_W-1:0]    r_time_step;
    logic [TIME_BITS-1:0] r_time;
    logic [TIME_BITS-1:0] n_time;
    logic [63:0]          time_wide;
    logic                 r_out_valid;
    t_out_item            r_out_item;
    logic                 pop;

    assign o_pop_ready = !r_out_valid || i_out_ready;
    assign pop = i_pop_valid && o_pop_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out_item;

    // The sum wraps in TIME_BITS bits; a narrow counter only sees the low step bits.
    assign n_time = i_pop_data.time_step
                    ? TIME_BITS'(r_time + TIME_BITS'(r_time_step)) : r_time;
    assign time_wide = 64'(n_time);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
            r_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_time_step_we) begin
                r_time_step <= i_time_step;
            end
            if (pop) begin
                r_time <= n_time;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_item.out_byte <= i_pop_data.data_byte;
            r_out_item.unit_start <= i_pop_data.unit_start;
            r_out_item.unit_time <= time_wide[OUT_TIME_W-1:0];
        end
    end

endmodule

### sv/access_unit_splitter.sv
// Top level: byte stream access unit splitter with timestamped units.
//
//   Channel   Direction  Signals                                  Beat
//   input     in         i_in_valid, o_in_ready, i_in_item        one stream byte or restart
//   output    out        o_out_valid, i_out_ready, o_out_item     one delayed byte with unit info
//   config    in         i_time_step_we, i_time_step              write of the time step
//
// One input beat is taken every cycle while the queue has room; each byte leaves four input bytes later,
// and an emitted beat is written into the queue and then loaded into the output register.
// The rate is set by the front's window shift and compare and the back's single timestamp
// add, so one beat moves through each part per cycle unless the output stalls.
// Reset is synchronous and clears the window state, the queue and the timestamp.
// A stalled output fills the four-entry queue before the input stalls.
module access_unit_splitter #(
    parameter int unsigned TIME_BITS = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_time_step_we,
    input  logic [aus_pkg::STEP_W-1:0] i_time_step,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  aus_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output aus_pkg::t_out_item         o_out_item
);
    import aus_pkg::*;

    logic  push_valid;
    logic  push_ready;
    t_work push_data;
    logic  pop_valid;
    logic  pop_ready;
    t_work pop_data;

    aus_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    aus_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    aus_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_time_step_we (i_time_step_we),
        .i_time_step    (i_time_step),
        .i_pop_valid    (pop_valid),
        .o_pop_ready    (pop_ready),
        .i_pop_data     (pop_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_item     (o_out_item)
    );

endmodule

### tb/sv/access_unit_splitter_tb.sv
// Self-checking testbench for the access unit splitter, with its own model of the byte window.
module access_unit_splitter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aus_pkg::*;

    localparam int unsigned TIME_BITS = 48;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned ITEM_TARGET = 700;
    localparam logic [STEP_W-1:0] STEP_FIELD_MAX = '1;
    localparam logic [STEP_W-1:0] STEP_RANGE_MAX = 20'd1000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_time_step_we = 1'b0;
    logic [STEP_W-1:0] i_time_step = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_item = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_item;

    // Model of the splitter state.
    logic [7:0]           win [4];
    int unsigned          fill;
    logic                 synced;
    logic                 slice_seen;
    logic [TIME_BITS-1:0] stamp;
    logic [STEP_W-1:0]    step_now;

    t_out_item   unit_beats_due [$];
    t_out_item   due_beat;
    int unsigned errors = 0;
    int unsigned beats_taken = 0;
    int unsigned beats_checked = 0;
    int unsigned units_opened = 0;
    int unsigned steps_written = 0;
    int unsigned idle_cycles = 0;
    logic        gaps_on = 1'b1;
    logic        hold_req = 1'b0;

    access_unit_splitter #(
        .TIME_BITS(TIME_BITS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_time_step_we(i_time_step_we),
        .i_time_step   (i_time_step),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_item    (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    task automatic clear_window();
        for (int k = 0; k < 4; k++) win[k] = 8'h00;
        fill = 0;
        synced = 1'b0;
        slice_seen = 1'b0;
    endtask

    // Advances the model by one accepted beat and queues the byte it releases, if any.
    task automatic track_stream_beat(input t_in_item item);
        logic [7:0] leaving;
        logic [7:0] hdr_type;
        logic       start_code;
        logic       is_slice;
        logic       open_unit;
        t_out_item  beat;
        if (item.restart) begin
            clear_window();
            return;
        end
        if (fill < 4) begin
            win[fill] = item.data_byte;
            fill++;
            return;
        end
        leaving = win[0];
        hdr_type = win[3] & NAL_TYPE_MASK;
        start_code = (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h01);
        is_slice = start_code && ((hdr_type == {3'b000, NAL_SLICE_NON_IDR})
                                  || (hdr_type == {3'b000, NAL_SLICE_IDR}));
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = item.data_byte;
        open_unit = 1'b0;
        if (!synced) begin
            if (!start_code) return;
            synced = 1'b1;
            open_unit = 1'b1;
            if (is_slice) slice_seen = 1'b1;
        end else if (is_slice) begin
            // A new unit opens only on a first slice once some slice has gone by.
            if (((item.data_byte & FIRST_SLICE_BIT) != 8'h00) && slice_seen) begin
                open_unit = 1'b1;
                stamp = stamp + {{(TIME_BITS - STEP_W){1'b0}}, step_now};
            end
            slice_seen = 1'b1;
        end
        if (open_unit) units_opened++;
        beat.out_byte = leaving;
        beat.unit_start = open_unit;
        beat.unit_time = stamp[OUT_TIME_W-1:0];
        unit_beats_due.push_back(beat);
    endtask

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_beat(input t_in_item item);
        if (gaps_on) begin
            while ($urandom_range(99) < 20) begin
                i_in_valid = 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid = 1'b1;
        i_in_item = item;
        do @(posedge i_clk); while (!o_in_ready);
        track_stream_beat(item);
        beats_taken++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] data);
        t_in_item item;
        item.data_byte = data;
        item.restart = 1'b0;
        send_beat(item);
    endtask

    task automatic send_restart();
        t_in_item item;
        item.data_byte = 8'($urandom_range(255));
        item.restart = 1'b1;
        send_beat(item);
    endtask

    function automatic logic [7:0] pick_nal_header();
        logic [7:0] header;
        header = 8'($urandom_range(255));
        case ($urandom_range(9))
            0, 1, 2, 3: header[4:0] = NAL_SLICE_NON_IDR;
            4, 5, 6:    header[4:0] = NAL_SLICE_IDR;
            default:    ;
        endcase
        return header;
    endfunction

    // One NAL unit: start code (sometimes the four-byte form), header, random payload.
    task automatic send_nal(input logic [7:0] header, input int unsigned payload_len);
        if ($urandom_range(99) < 30) send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(header);
        for (int k = 0; k < payload_len; k++) send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_random_nal();
        int unsigned len;
        len = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(1, 8);
        send_nal(pick_nal_header(), len);
    endtask

    task automatic settle_pipeline();
        i_in_valid = 1'b0;
        while (unit_beats_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_time_step(input logic [STEP_W-1:0] step);
        settle_pipeline();
        i_time_step_we = 1'b1;
        i_time_step = step;
        step_now = step;
        @(negedge i_clk);
        i_time_step_we = 1'b0;
        steps_written++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Reset time step, bytes before sync, unit opening rules and restart.
    task automatic test_directed_stream();
        logic [7:0] opening [21] = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'h65, 8'h88,
                                    8'h00, 8'h00, 8'h01, 8'h41, 8'h9A,
                                    8'h00, 8'h00, 8'h01, 8'h41, 8'h1A,
                                    8'h00, 8'h00, 8'h01, 8'h06, 8'h80};
        foreach (opening[k]) send_byte(opening[k]);
        send_restart();
        // After the restart the first unit keeps the current time.
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hE5);
        send_byte(8'h80);
    endtask

    task automatic test_time_step_extremes();
        logic [STEP_W-1:0] steps [4] = '{20'd0, STEP_FIELD_MAX, STEP_RANGE_MAX, 20'd1};
        foreach (steps[k]) begin
            program_time_step(steps[k]);
            send_restart();
            send_nal({3'b011, NAL_SLICE_IDR}, 3);
            for (int n = 0; n < 4; n++) send_random_nal();
        end
    endtask

    task automatic test_back_to_back();
        int unsigned start;
        start = beats_taken;
        gaps_on = 1'b0;
        while (beats_taken < start + 120) send_random_nal();
        gaps_on = 1'b1;
    endtask

    // The receiver stalls long enough for the output queue to fill and back-pressure the input.
    task automatic test_output_hold_off();
        int unsigned start;
        start = beats_taken;
        gaps_on = 1'b0;
        hold_req = 1'b1;
        while (beats_taken < start + 80) send_random_nal();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_stream();
        int unsigned next_write;
        next_write = beats_taken + 150;
        while (beats_taken < ITEM_TARGET) begin
            if (beats_taken >= next_write) begin
                program_time_step(($urandom_range(9) == 0) ? 20'($urandom_range(1048575))
                                                           : 20'($urandom_range(1000000)));
                next_write = beats_taken + 150;
            end
            case ($urandom_range(19))
                0:       send_restart();
                1, 2:    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
                default: send_random_nal();
            endcase
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready = gaps_on ? ($urandom_range(99) >= 20) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_checked++;
            if (unit_beats_due.size() == 0) begin
                report_mismatch("unexpected beat", 64'(o_out_item.out_byte), 64'h0);
            end else begin
                due_beat = unit_beats_due.pop_front();
                if (o_out_item.out_byte !== due_beat.out_byte)
                    report_mismatch("out_byte", 64'(o_out_item.out_byte),
                                    64'(due_beat.out_byte));
                if (o_out_item.unit_start !== due_beat.unit_start)
                    report_mismatch("unit_start", 64'(o_out_item.unit_start),
                                    64'(due_beat.unit_start));
                if (o_out_item.unit_time !== due_beat.unit_time)
                    report_mismatch("unit_time", 64'(o_out_item.unit_time),
                                    64'(due_beat.unit_time));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles.", STALL_LIMIT);
            $display("access_unit_splitter verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_window();
        stamp = '0;
        step_now = TIME_STEP_RESET;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_stream();
        test_time_step_extremes();
        test_back_to_back();
        test_output_hold_off();
        test_random_stream();
        settle_pipeline();
        $display("Sent %0d input beats and checked %0d output beats across %0d units.",
                 beats_taken, beats_checked, units_opened);
        $display("Time step was reprogrammed %0d times, including zero and full scale.",
                 steps_written);
        if (errors == 0) begin
            $display("access_unit_splitter verification clean");
        end else begin
            $display("access_unit_splitter verification failed");
        end
        $finish;
    end

endmodule
